>>> hdl/tgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tgm_pkg;
   localparam int DefGridCols = 8;
   localparam int DefGridRows = 8;
   localparam int MaxBlocks   = 64;

   typedef struct packed {
      logic        operation;
      logic [2:0]  col;
      logic [2:0]  row;
      logic [15:0] handle;
      logic [15:0] weight;
      logic [7:0]  stride;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [2:0]  block_x;
      logic [2:0]  block_y;
      logic [3:0]  width;
      logic [3:0]  height;
      logic [15:0] block_handle;
      logic [15:0] block_weight;
      logic        last;
   } rsp_type;

   localparam logic OpLoad = 1'b0;
   localparam logic OpRun  = 1'b1;
endpackage
`default_nettype wire

>>> hdl/tgm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tgm_req_if;
   logic valid;
   logic ready;
   tgm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tgm_rsp_if;
   logic valid;
   logic ready;
   tgm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/tgm_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// weight mod stride by restoring subtraction, one bit a cycle
module tgm_mod (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [7:0]  divisor,
   output logic             done,
   output logic [7:0]       remainder
);
   logic [4:0]  count_ff, count_in;
   logic [15:0] quot_ff, quot_in;
   logic [8:0]  rem_ff, rem_in;
   logic        busy_ff, busy_in;
   logic [8:0]  trial;

   always_comb begin
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff[7:0], quot_ff[15]};
      if (start) begin
         count_in = 5'd0;
         quot_in  = dividend;
         rem_in   = 9'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[14:0], 1'b0};
         if (trial >= {1'b0, divisor}) rem_in = trial - {1'b0, divisor};
         else rem_in = trial;
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd15) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= 5'd0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = busy_ff && !busy_in && !start;
   assign remainder = rem_in[7:0];
endmodule
`default_nettype wire

>>> hdl/tile_grid_greedy_rect_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// greedy rectangle merge over a tile grid
// req channel: load items (operation 0) write one tile in the accepting cycle
// and ready stays high, so loads can follow back to back. a run item
// (operation 1) first clears coverage row by row, then scans the grid
// row-major, reading one tile at a time through the shared read address.
// every scanned position is read, tested and advanced past. an anchor with
// a nonzero stride also runs the weight mod stride unit, reads and tests
// tiles to the right, commits its row, reads and tests tiles down, then
// hands the block over. an anchor with stride 0 goes straight to hand-over.
// each block is held until the next one is found or the scan ends, so the
// last flag is known when it goes out; a flush step then sends the final item,
// or a single not-found item. req ready is low from the run item until the
// final item is loaded into the rsp register. a stalled rsp holds the scan
// at the next block. reset clears coverage and control; tile memory is
// undefined until loaded.
module tile_grid_greedy_rect_merge #(
   parameter int GRID_COLS = tgm_pkg::DefGridCols,
   parameter int GRID_ROWS = tgm_pkg::DefGridRows
) (
   input wire logic clock,
   input wire logic reset,
   tgm_req_if.sink   req,
   tgm_rsp_if.source rsp
);
   import tgm_pkg::*;

   localparam int Tiles = GRID_COLS * GRID_ROWS;
   localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int AW = (Tiles > 1) ? $clog2(Tiles) : 1;
   localparam int CXW = $clog2(GRID_COLS + 1);
   localparam int CYW = $clog2(GRID_ROWS + 1);
   localparam int LW = CW + 9;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_ANCHOR_RD, S_ANCHOR, S_MOD, S_RIGHT_RD, S_RIGHT,
      S_DOWN_RD, S_DOWN, S_EMIT, S_NEXT, S_FLUSH
   } state_type;

   state_type state_ff;
   logic [15:0] hmem [Tiles];
   logic [15:0] wmem [Tiles];
   logic [7:0]  smem [Tiles];
   logic [15:0] rd_h_ff;
   logic [15:0] rd_w_ff;
   logic [7:0]  rd_s_ff;
   logic [GRID_COLS-1:0] cov_ff [GRID_ROWS];

   logic [CW-1:0] x_ff, ix_ff;
   logic [RW-1:0] y_ff, iy_ff;
   logic [CXW-1:0] cx_ff;
   logic [CYW-1:0] cy_ff;
   logic [15:0] h_ff, w_ff, roww_ff, expw_ff;
   logic [7:0]  s_ff;
   logic [LW-1:0] limit_ff;
   logic [6:0]  count_ff;
   logic        any_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     hold_ff;
   rsp_type     flush_item;
   logic        rsp_free, rsp_load;
   logic        mod_start, mod_done;
   logic [7:0]  mod_rem;
   logic [AW-1:0] rd_addr;
   logic [RW-1:0] rd_row;
   logic [CW-1:0] rd_col;
   logic [RW:0]   clr_ff;
   logic [GRID_COLS-1:0] mask;

   tgm_mod u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(rd_w_ff),
      .divisor(s_ff), .done(mod_done), .remainder(mod_rem)
   );

   assign mod_start = (state_ff == S_ANCHOR) && !(cov_ff[y_ff][x_ff] || rd_h_ff == 16'd0)
                      && rd_s_ff != 8'd0;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign rsp_load  = rsp_free && ((state_ff == S_EMIT && any_ff) || state_ff == S_FLUSH);

   always_comb begin
      rd_row = y_ff;
      rd_col = x_ff;
      if (state_ff == S_RIGHT_RD || state_ff == S_DOWN_RD) begin
         rd_row = iy_ff;
         rd_col = ix_ff;
      end
      rd_addr = AW'(rd_row * GRID_COLS + rd_col);
      mask = '0;
      for (int i = 0; i < GRID_COLS; i++)
         mask[i] = (i >= int'(x_ff)) && (i < int'(x_ff) + int'(cx_ff));
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req.valid && req.data.operation == OpLoad &&
          int'(req.data.col) < GRID_COLS && int'(req.data.row) < GRID_ROWS) begin
         hmem[AW'(int'(req.data.row) * GRID_COLS + int'(req.data.col))] <= req.data.handle;
         wmem[AW'(int'(req.data.row) * GRID_COLS + int'(req.data.col))] <= req.data.weight;
         smem[AW'(int'(req.data.row) * GRID_COLS + int'(req.data.col))] <= req.data.stride;
      end
      rd_h_ff <= hmem[rd_addr];
      rd_w_ff <= wmem[rd_addr];
      rd_s_ff <= smem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         clr_ff <= '0;
         for (int r = 0; r < GRID_ROWS; r++) cov_ff[r] <= '0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (rsp_load) rsp_ff <= (state_ff == S_FLUSH) ? flush_item : hold_ff;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.data.operation == OpRun) begin
                  clr_ff <= '0;
                  state_ff <= S_CLEAR;
               end
            end
            S_CLEAR: begin
               // one coverage row a cycle
               cov_ff[clr_ff[RW-1:0]] <= '0;
               if (int'(clr_ff) == GRID_ROWS - 1) begin
                  x_ff <= '0;
                  y_ff <= '0;
                  count_ff <= '0;
                  any_ff <= 1'b0;
                  state_ff <= S_ANCHOR_RD;
               end
               clr_ff <= clr_ff + 1'b1;
            end
            S_ANCHOR_RD: state_ff <= S_ANCHOR;
            S_ANCHOR: begin
               h_ff <= rd_h_ff;
               w_ff <= rd_w_ff;
               s_ff <= rd_s_ff;
               cx_ff <= CXW'(1);
               cy_ff <= CYW'(1);
               if (cov_ff[y_ff][x_ff] || rd_h_ff == 16'd0) begin
                  state_ff <= S_NEXT;
               end else if (rd_s_ff == 8'd0) begin
                  cov_ff[y_ff][x_ff] <= 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               if (mod_done) begin
                  limit_ff <= LW'(x_ff) + LW'(s_ff) - LW'(mod_rem);
                  ix_ff <= x_ff + 1'b1;
                  iy_ff <= y_ff;
                  expw_ff <= w_ff + 16'd1;
                  if (int'(x_ff) + 1 >= GRID_COLS ||
                      LW'(x_ff) + LW'(s_ff) - LW'(mod_rem) <= LW'(x_ff) + LW'(1))
                     state_ff <= S_DOWN_RD;
                  else state_ff <= S_RIGHT_RD;
               end
            end
            S_RIGHT_RD: state_ff <= S_RIGHT;
            S_RIGHT: begin
               if (!cov_ff[y_ff][ix_ff] && rd_h_ff == h_ff && rd_w_ff == expw_ff) begin
                  cx_ff <= cx_ff + 1'b1;
                  expw_ff <= expw_ff + 16'd1;
                  ix_ff <= ix_ff + 1'b1;
                  if (int'(ix_ff) + 1 >= GRID_COLS ||
                      LW'(ix_ff) + LW'(1) >= limit_ff)
                     state_ff <= S_DOWN_RD;
                  else state_ff <= S_RIGHT_RD;
               end else state_ff <= S_DOWN_RD;
            end
            S_DOWN_RD: begin
               // first entry: commit anchor row coverage and set up next row
               if (iy_ff == y_ff) begin
                  cov_ff[y_ff] <= cov_ff[y_ff] | mask;
                  roww_ff <= w_ff + {8'd0, s_ff};
                  expw_ff <= w_ff + {8'd0, s_ff};
                  ix_ff <= x_ff;
                  if (int'(y_ff) + 1 >= GRID_ROWS) state_ff <= S_EMIT;
                  else iy_ff <= y_ff + 1'b1;
               end else state_ff <= S_DOWN;
            end
            S_DOWN: begin
               if (!cov_ff[iy_ff][ix_ff] && rd_h_ff == h_ff && rd_w_ff == expw_ff) begin
                  if (int'(ix_ff) + 1 == int'(x_ff) + int'(cx_ff)) begin
                     cov_ff[iy_ff] <= cov_ff[iy_ff] | mask;
                     cy_ff <= cy_ff + 1'b1;
                     roww_ff <= roww_ff + {8'd0, s_ff};
                     expw_ff <= roww_ff + {8'd0, s_ff};
                     ix_ff <= x_ff;
                     if (int'(iy_ff) + 1 >= GRID_ROWS) state_ff <= S_EMIT;
                     else begin
                        iy_ff <= iy_ff + 1'b1;
                        state_ff <= S_DOWN_RD;
                     end
                  end else begin
                     ix_ff <= ix_ff + 1'b1;
                     expw_ff <= expw_ff + 16'd1;
                     state_ff <= S_DOWN_RD;
                  end
               end else state_ff <= S_EMIT;
            end
            S_EMIT: begin
               // the previous block goes out, the new one is held
               if (!any_ff || rsp_free) begin
                  hold_ff.found <= 1'b1;
                  hold_ff.block_x <= 3'(x_ff);
                  hold_ff.block_y <= 3'(y_ff);
                  hold_ff.width <= 4'(cx_ff);
                  hold_ff.height <= 4'(cy_ff);
                  hold_ff.block_handle <= h_ff;
                  hold_ff.block_weight <= w_ff;
                  hold_ff.last <= 1'b0;
                  count_ff <= count_ff + 7'd1;
                  any_ff <= 1'b1;
                  if (count_ff == 7'(MaxBlocks - 1)) state_ff <= S_FLUSH;
                  else state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if (int'(x_ff) + int'(cx_ff) >= GRID_COLS) begin
                  x_ff <= '0;
                  if (int'(y_ff) + 1 >= GRID_ROWS) state_ff <= S_FLUSH;
                  else begin
                     y_ff <= y_ff + 1'b1;
                     state_ff <= S_ANCHOR_RD;
                  end
               end else begin
                  x_ff <= CW'(int'(x_ff) + int'(cx_ff));
                  state_ff <= S_ANCHOR_RD;
               end
            end
            S_FLUSH: begin
               if (rsp_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // final item: held block with last set, or not-found
   always_comb begin
      flush_item = hold_ff;
      if (!any_ff) flush_item = '0;
      flush_item.last = 1'b1;
   end

   property p_no_req_while_busy;
      @(posedge clock) disable iff (reset) (state_ff != S_IDLE) |-> !req.ready;
   endproperty
   assert property (p_no_req_while_busy) else $error("ready while busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff)
      else $error("result dropped under stall");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> $stable(rsp_ff))
      else $error("result changed under stall");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (cx_ff != '0 && cy_ff != '0))
      else $error("empty rectangle");
endmodule
`default_nettype wire
